### hdl/swmv_pkg.sv
// Shared types and constants for the sliding-window mean and variance block.
`timescale 1ns / 1ps

package swmv_pkg;

  // Configuration register
  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd16;

  // Result field widths that do not follow the sample width
  localparam int POS_W = 32;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam int VAR_W = 47;

  // Item kinds carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_UPDATE,
    ST_PRODUCT_START,
    ST_PRODUCT,
    ST_DIVIDE,
    ST_DELIVER
  } swmv_state_t;

endpackage

### hdl/swmv_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module swmv_mul #(
  parameter int A_W = 55,
  parameter int B_W = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [P_W-1:0]   p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(B_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= P_W'(a);
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign busy = busy_r;
  assign prod = p_r;

endmodule

### hdl/swmv_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module swmv_div #(
  parameter int N_W = 64,
  parameter int D_W = 18
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           busy,
  output logic [N_W-1:0] quo
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   n_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   d_r;

  logic [D_W:0]     rem_sh;
  logic [D_W:0]     diff;
  logic             ge;

  assign rem_sh = {rem_r, n_r[N_W-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift the dividend out the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      rem_r <= '0;
      d_r   <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
      n_r   <= {n_r[N_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = n_r;

endmodule

### hdl/sliding_window_mean_variance.sv
// Top level: sample ring, running sums and sequencer for window mean and variance.
//
//   channel | direction | tdata (low bit up)                        | tuser
//   in_     | slave     | sample                                    | kind
//   out_    | master    | position, window_mean, window_variance    | -
//   cfg_    | write     | window_len                                | -
//
// A clear item, or a cfg write, starts no sequence. A sample during warm-up steps
// through read, square and update; a sample with a result goes on through product
// start, product and divide, waiting on the multipliers and divider, then deliver.
// in_tready is high only while the sequencer is idle; a finished result waits in
// the output register and does not block the next transaction.
// rst_n is synchronous; after reset window_len is 16 and the history is empty.
`timescale 1ns / 1ps

module sliding_window_mean_variance #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                          cfg_wr_en,
  input  logic [swmv_pkg::CFG_W-1:0]                    cfg_wr_data,  // window_len

  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]              in_tdata,     // sample
  input  logic                                          in_tuser,     // kind

  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // position, window_mean, window_variance
  output logic [((swmv_pkg::POS_W+SAMPLE_BITS+swmv_pkg::VAR_W+7)/8)*8-1:0] out_tdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int LOG_W  = $clog2(WINDOW_MAX);
  localparam int W_W    = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = LOG_W;
  localparam int SUM_W  = SB + LOG_W;
  localparam int SQ_W   = 2 * SB - 1 + LOG_W;
  localparam int N_W    = SQ_W + W_W;
  localparam int MB_W   = (SB > W_W) ? SB : W_W;
  localparam int CMP_W  = (swmv_pkg::CFG_W > W_W) ? swmv_pkg::CFG_W : W_W;
  localparam int OUT_FW = swmv_pkg::POS_W + SB + swmv_pkg::VAR_W;
  localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;
  localparam int EXT_W  = N_W + swmv_pkg::VAR_W;

  swmv_pkg::swmv_state_t state_r, state_nxt;

  logic [swmv_pkg::CFG_W-1:0] cfg_len_r;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic [W_W-1:0]             fill_r, fill_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;
  logic [swmv_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]          out_data_r, out_data_nxt;
  logic [SB-1:0]              x_r, x_nxt;
  logic [SB-1:0]              rd_r;

  logic [SB-1:0] ring_mem [WINDOW_MAX];

  logic               in_acc;
  logic               mem_we;
  logic               mul_start;
  logic               div_start;
  logic [W_W-1:0]     w_eff;
  logic [CMP_W-1:0]   cfg_ext;
  logic [W_W:0]       slot_ext;
  logic [W_W:0]       w_ext;
  logic [W_W:0]       old_ext;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SB-1:0]      x_mag;
  logic [SB-1:0]      y_mag;
  logic [SUM_W-1:0]   sum_mag;
  logic [W_W:0]       fill_p1;
  logic               full_before;

  logic [SQ_W-1:0]        mul_a_a;
  logic [MB_W-1:0]        mul_a_b;
  logic [SUM_W-1:0]       mul_b_op;
  logic                   mul_a_busy, mul_b_busy;
  logic [SQ_W+MB_W-1:0]   mul_a_prod;
  logic [2*SUM_W-1:0]     mul_b_prod;

  logic [N_W-1:0]         var_num;
  logic [2*W_W-1:0]       w_sq;
  logic                   div_v_busy, div_m_busy;
  logic [N_W-1:0]         var_quo;
  logic [SUM_W-1:0]       mean_quo;
  logic [EXT_W-1:0]       var_ext;
  logic [SUM_W-1:0]       mean_full;

  assign in_acc = in_tvalid && in_tready;

  // Zero counts as one; anything beyond the ring depth is clamped to it.
  always_comb begin
    cfg_ext = CMP_W'(cfg_len_r);
    if (cfg_ext == '0) begin
      w_eff = W_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      w_eff = W_W'(WINDOW_MAX);
    end else begin
      w_eff = W_W'(cfg_ext);
    end
  end

  // Oldest sample in the window sits w slots behind the write slot.
  assign slot_ext = (W_W+1)'(slot_r);
  assign w_ext    = (W_W+1)'(w_eff);
  assign old_ext  = (slot_ext >= w_ext) ? (slot_ext - w_ext)
                                        : (slot_ext + (W_W+1)'(WINDOW_MAX) - w_ext);
  assign rd_addr  = old_ext[SLOT_W-1:0];

  // Read before write, so a full-depth window still sees the evicted sample.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rd_r              <= ring_mem[rd_addr];
      ring_mem[slot_r]  <= x_nxt;
    end
  end

  assign x_mag   = x_r[SB-1] ? (~x_r + 1'b1) : x_r;
  assign y_mag   = rd_r[SB-1] ? (~rd_r + 1'b1) : rd_r;
  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // First pass squares the new and old samples; second forms w*sumsq and sum^2.
  always_comb begin
    if (state_r == swmv_pkg::ST_READ) begin
      mul_a_a  = SQ_W'(x_mag);
      mul_a_b  = MB_W'(x_mag);
      mul_b_op = SUM_W'(y_mag);
    end else begin
      mul_a_a  = sq_r;
      mul_a_b  = MB_W'(w_eff);
      mul_b_op = sum_mag;
    end
  end

  assign mul_start = (state_r == swmv_pkg::ST_READ) ||
                     (state_r == swmv_pkg::ST_PRODUCT_START);

  swmv_mul #(.A_W(SQ_W), .B_W(MB_W)) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a_a),
    .b     (mul_a_b),
    .busy  (mul_a_busy),
    .prod  (mul_a_prod)
  );

  swmv_mul #(.A_W(SUM_W), .B_W(SUM_W)) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_b_op),
    .b     (mul_b_op),
    .busy  (mul_b_busy),
    .prod  (mul_b_prod)
  );

  assign var_num = mul_a_prod[N_W-1:0] - mul_b_prod[N_W-1:0];
  assign w_sq    = w_eff * w_eff;

  swmv_div #(.N_W(N_W), .D_W(2*W_W)) u_div_var (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (var_num),
    .den   (w_sq),
    .busy  (div_v_busy),
    .quo   (var_quo)
  );

  swmv_div #(.N_W(SUM_W), .D_W(W_W)) u_div_mean (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_mag),
    .den   (w_eff),
    .busy  (div_m_busy),
    .quo   (mean_quo)
  );

  assign var_ext   = EXT_W'(var_quo);
  assign mean_full = sum_r[SUM_W-1] ? (~mean_quo + 1'b1) : mean_quo;

  assign fill_p1     = (W_W+1)'(fill_r) + 1'b1;
  assign full_before = fill_r >= w_eff;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    pos_nxt       = pos_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      swmv_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == swmv_pkg::KIND_CLEAR) begin
            slot_nxt = '0;
            fill_nxt = '0;
            sum_nxt  = '0;
            sq_nxt   = '0;
            pos_nxt  = '0;
          end else begin
            x_nxt     = in_tdata[SB-1:0];
            mem_we    = 1'b1;
            slot_nxt  = (slot_r == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_r + 1'b1;
            state_nxt = swmv_pkg::ST_READ;
          end
        end
      end
      swmv_pkg::ST_READ: begin
        state_nxt = swmv_pkg::ST_SQUARE;
      end
      swmv_pkg::ST_SQUARE: begin
        if (!mul_a_busy && !mul_b_busy) begin
          state_nxt = swmv_pkg::ST_UPDATE;
        end
      end
      swmv_pkg::ST_UPDATE: begin
        if (full_before) begin
          sum_nxt = sum_r - {{LOG_W{rd_r[SB-1]}}, rd_r} + {{LOG_W{x_r[SB-1]}}, x_r};
          sq_nxt  = sq_r - mul_b_prod[SQ_W-1:0] + mul_a_prod[SQ_W-1:0];
        end else begin
          fill_nxt = fill_p1[W_W-1:0];
          sum_nxt  = sum_r + {{LOG_W{x_r[SB-1]}}, x_r};
          sq_nxt   = sq_r + mul_a_prod[SQ_W-1:0];
        end
        if (pos_r != swmv_pkg::POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (full_before || (fill_p1 >= w_ext)) begin
          state_nxt = swmv_pkg::ST_PRODUCT_START;
        end else begin
          state_nxt = swmv_pkg::ST_IDLE;
        end
      end
      swmv_pkg::ST_PRODUCT_START: begin
        state_nxt = swmv_pkg::ST_PRODUCT;
      end
      swmv_pkg::ST_PRODUCT: begin
        if (!mul_a_busy && !mul_b_busy) begin
          div_start = 1'b1;
          state_nxt = swmv_pkg::ST_DIVIDE;
        end
      end
      swmv_pkg::ST_DIVIDE: begin
        if (!div_v_busy && !div_m_busy) begin
          state_nxt = swmv_pkg::ST_DELIVER;
        end
      end
      swmv_pkg::ST_DELIVER: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DW'({var_ext[swmv_pkg::VAR_W-1:0], mean_full[SB-1:0], pos_r});
          state_nxt     = swmv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swmv_pkg::ST_IDLE;
      end
    endcase

    // A new window length empties the history like a clear transaction.
    if (cfg_wr_en) begin
      slot_nxt = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
      sq_nxt   = '0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swmv_pkg::ST_IDLE;
      cfg_len_r   <= swmv_pkg::CFG_RESET;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == swmv_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
